>>> sv/assert_macros.svh
// Assertion macros shared by the shift/rotate unit RTL.
// Clock and reset are taken as clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/srot_pkg.sv
// Shared types, constants and helpers for the x86 shift/rotate unit.
// No dependencies; used by every module of the block.
package srot_pkg;

  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned DW         = 65;  // funnel word width
  localparam int unsigned CW         = 40;  // width kept after coarse shift
  localparam int unsigned YW         = 33;  // width kept after fine shift
  localparam int unsigned AMT_W      = 6;   // right shift amount, 0..32
  localparam int unsigned NUM_STAGES = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ROL  = 3'd0,
    ACT_ROR  = 3'd1,
    ACT_RCL  = 3'd2,
    ACT_RCR  = 3'd3,
    ACT_SHL  = 3'd4,
    ACT_SHR  = 3'd5,
    ACT_SAR  = 3'd6,
    ACT_PASS = 3'd7
  } action_e;

  // where the new carry comes from after the funnel shift
  typedef enum logic [1:0] {
    CSEL_CIN = 2'd0,
    CSEL_TOP = 2'd1,
    CSEL_LOW = 2'd2
  } csel_e;

  typedef struct packed {
    logic  wide;
    logic  shr_align;  // result sits one bit up (shr/sar carry in bit 0)
    csel_e csel;
    logic  cin;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [DW-1:0]    d;
    logic [AMT_W-1:0] amt;
  } prep_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } flow_t;

  // count modulo 9 for counts 0..31
  function automatic logic [3:0] mod9(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] r;
    priority if (n >= 5'd27) r = n - 5'd27;
    else if (n >= 5'd18)     r = n - 5'd18;
    else if (n >= 5'd9)      r = n - 5'd9;
    else                     r = n;
    return r[3:0];
  endfunction

endpackage

>>> sv/srot_prep.sv
// Operand setup: builds the funnel word and the right shift amount per operation.
// Combinational; depends on srot_pkg.
module srot_prep (
  input  logic [srot_pkg::ACTION_W-1:0] action_i,
  input  logic                          wide_i,
  input  logic [srot_pkg::VALUE_W-1:0]  value_i,
  input  logic [srot_pkg::COUNT_W-1:0]  count_i,
  input  logic                          carry_in_i,
  output srot_pkg::prep_t               prep_o
);

  logic [srot_pkg::VALUE_W-1:0] v;
  logic [4:0]                   k_rot;
  logic [5:0]                   k_rc;
  logic [5:0]                   m_rot;
  logic [5:0]                   m_rc;
  logic                         sign;
  logic [32:0]                  x33;
  logic [8:0]                   x9;

  always_comb begin
    v     = wide_i ? value_i : {24'd0, value_i[7:0]};
    k_rot = wide_i ? count_i : {2'b00, count_i[2:0]};
    k_rc  = wide_i ? {1'b0, count_i} : {2'b00, srot_pkg::mod9(count_i)};
    m_rot = wide_i ? 6'd32 : 6'd8;
    m_rc  = wide_i ? 6'd33 : 6'd9;
    sign  = wide_i ? value_i[31] : value_i[7];
    x33   = {carry_in_i, v};
    x9    = {carry_in_i, v[7:0]};

    prep_o.ctl.wide      = wide_i;
    prep_o.ctl.shr_align = 1'b0;
    prep_o.ctl.csel      = srot_pkg::CSEL_CIN;
    prep_o.ctl.cin       = carry_in_i;
    prep_o.d             = {33'd0, v};
    prep_o.amt           = '0;

    unique case (srot_pkg::action_e'(action_i))
      srot_pkg::ACT_ROL, srot_pkg::ACT_ROR: begin
        prep_o.d = wide_i ? {v[0], v, v} : {49'd0, v[7:0], v[7:0]};
        if (srot_pkg::action_e'(action_i) == srot_pkg::ACT_ROR) begin
          prep_o.amt = {1'b0, k_rot};
        end else begin
          prep_o.amt = (k_rot == 5'd0) ? 6'd0 : m_rot - {1'b0, k_rot};
        end
      end
      srot_pkg::ACT_RCL, srot_pkg::ACT_RCR: begin
        prep_o.d        = wide_i ? {x33[31:0], x33} : {47'd0, x9, x9};
        prep_o.ctl.csel = srot_pkg::CSEL_TOP;
        if (srot_pkg::action_e'(action_i) == srot_pkg::ACT_RCR) begin
          prep_o.amt = k_rc;
        end else begin
          prep_o.amt = (k_rc == 6'd0) ? 6'd0 : m_rc - k_rc;
        end
      end
      srot_pkg::ACT_SHL: begin
        // left shift done as a right shift of the operand parked above the width
        prep_o.ctl.csel = srot_pkg::CSEL_TOP;
        if (wide_i) begin
          prep_o.d   = {1'b0, v, 32'd0};
          prep_o.amt = 6'd32 - {1'b0, count_i};
        end else if (count_i > 5'd8) begin
          prep_o.d   = '0;
          prep_o.amt = 6'd0;
        end else begin
          prep_o.d   = {49'd0, v[7:0], 8'd0};
          prep_o.amt = 6'd8 - {1'b0, count_i};
        end
      end
      srot_pkg::ACT_SHR: begin
        prep_o.d             = {32'd0, v, carry_in_i};
        prep_o.amt           = {1'b0, count_i};
        prep_o.ctl.csel      = srot_pkg::CSEL_LOW;
        prep_o.ctl.shr_align = 1'b1;
      end
      srot_pkg::ACT_SAR: begin
        prep_o.d             = wide_i ? {{32{sign}}, v, carry_in_i}
                                      : {{56{sign}}, v[7:0], carry_in_i};
        prep_o.amt           = {1'b0, count_i};
        prep_o.ctl.csel      = srot_pkg::CSEL_LOW;
        prep_o.ctl.shr_align = 1'b1;
      end
      srot_pkg::ACT_PASS: begin
        prep_o.d = {33'd0, v};
      end
    endcase
  end

endmodule

>>> sv/srot_fmt.sv
// Result formatting: picks the result window and the carry from the shifted word.
// Combinational; depends on srot_pkg.
module srot_fmt (
  input  srot_pkg::ctl_t               ctl_i,
  input  logic [srot_pkg::YW-1:0]      y_i,
  output logic [srot_pkg::VALUE_W-1:0] result_o,
  output logic                         carry_out_o
);

  logic [srot_pkg::VALUE_W-1:0] raw;

  always_comb begin
    raw      = ctl_i.shr_align ? y_i[32:1] : y_i[31:0];
    result_o = ctl_i.wide ? raw : {24'd0, raw[7:0]};
    unique case (ctl_i.csel)
      srot_pkg::CSEL_CIN: carry_out_o = ctl_i.cin;
      srot_pkg::CSEL_TOP: carry_out_o = ctl_i.wide ? y_i[32] : y_i[8];
      srot_pkg::CSEL_LOW: carry_out_o = y_i[0];
      default:            carry_out_o = ctl_i.cin;
    endcase
  end

endmodule

>>> sv/srot_flow.sv
// Pipeline flow control: per-stage valid bits and load enables with backpressure.
// Depends on srot_pkg.
module srot_flow (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output srot_pkg::flow_t flow_o
);

  logic [srot_pkg::NUM_STAGES-1:0] valid_q;
  logic [srot_pkg::NUM_STAGES-1:0] valid_d;
  logic [srot_pkg::NUM_STAGES-1:0] rdy;
  logic [srot_pkg::NUM_STAGES-1:0] vin;

  always_comb begin
    rdy[srot_pkg::NUM_STAGES-1] = !valid_q[srot_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = srot_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin = {valid_q[srot_pkg::NUM_STAGES-2:0], in_valid_i};
    for (int k = 0; k < srot_pkg::NUM_STAGES; k++) begin
      valid_d[k]     = rdy[k] ? vin[k] : valid_q[k];
      flow_o.load[k] = rdy[k] && vin[k];
    end
    flow_o.valid = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[srot_pkg::NUM_STAGES-1];

endmodule

>>> sv/x86_shift_rotate_unit_top.sv
// Top level of the x86 shift/rotate unit: four-stage funnel shifter pipeline.
// Depends on srot_pkg, srot_prep, srot_fmt, srot_flow and assert_macros.svh.
//
//   channel   direction  handshake                  payload
//   request   in         in_valid_i / in_ready_o    action, wide, value, count, carry_in
//   result    out        out_valid_o / out_ready_i  result, carry_out
//
// One request per cycle while the output is not stalled; each result passes s1, s2, s3 and the result register.
// Stages: operand setup, shift by multiples of 8, shift by 0..7, format/output.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall at the output fills the stages back to front; none is lost or repeated.
`include "assert_macros.svh"

module x86_shift_rotate_unit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [srot_pkg::ACTION_W-1:0] action_i,
  input  logic                          wide_i,
  input  logic [srot_pkg::VALUE_W-1:0]  value_i,
  input  logic [srot_pkg::COUNT_W-1:0]  count_i,
  input  logic                          carry_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [srot_pkg::VALUE_W-1:0]  result_o,
  output logic                          carry_out_o
);

  srot_pkg::flow_t                flow;
  srot_pkg::prep_t                prep;
  srot_pkg::prep_t                s1_q;
  srot_pkg::ctl_t                 s2_ctl_q;
  logic [srot_pkg::CW-1:0]        s2_c_q;
  logic [2:0]                     s2_fine_q;
  srot_pkg::ctl_t                 s3_ctl_q;
  logic [srot_pkg::YW-1:0]        s3_y_q;
  logic [srot_pkg::VALUE_W-1:0]   result_d;
  logic                           carry_d;
  logic [srot_pkg::VALUE_W-1:0]   result_q;
  logic                           carry_q;
  logic [srot_pkg::DW-1:0]        coarse;
  logic [srot_pkg::CW-1:0]        fine;

  srot_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .flow_o      (flow)
  );

  srot_prep u_prep (
    .action_i   (action_i),
    .wide_i     (wide_i),
    .value_i    (value_i),
    .count_i    (count_i),
    .carry_in_i (carry_in_i),
    .prep_o     (prep)
  );

  assign coarse = s1_q.d >> {s1_q.amt[5:3], 3'b000};
  assign fine   = s2_c_q >> s2_fine_q;

  srot_fmt u_fmt (
    .ctl_i       (s3_ctl_q),
    .y_i         (s3_y_q),
    .result_o    (result_d),
    .carry_out_o (carry_d)
  );

  always_ff @(posedge clk_i) begin
    if (flow.load[0]) begin
      s1_q <= prep;
    end
    if (flow.load[1]) begin
      s2_ctl_q  <= s1_q.ctl;
      s2_c_q    <= coarse[srot_pkg::CW-1:0];
      s2_fine_q <= s1_q.amt[2:0];
    end
    if (flow.load[2]) begin
      s3_ctl_q <= s2_ctl_q;
      s3_y_q   <= fine[srot_pkg::YW-1:0];
    end
    if (flow.load[3]) begin
      result_q <= result_d;
      carry_q  <= carry_d;
    end
  end

  assign result_o    = result_q;
  assign carry_out_o = carry_q;

  `SRT_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && in_ready_o, flow.valid[0], "request lost at entry")
  `SRT_ASSERT(a_stall_only_when_full, !in_ready_o |-> (&flow.valid), "stall with an empty stage")
  `SRT_ASSERT_NEXT(a_s3_holds_on_stall, out_valid_o && !out_ready_i && flow.valid[2], flow.valid[2] && $stable(s3_y_q), "stage 3 changed under stall")
  `SRT_ASSERT_NEXT(a_drain_empties_out, out_valid_o && out_ready_i && !flow.valid[2], !out_valid_o, "result repeated")

endmodule

>>> tb/tb_x86_shift_rotate_unit_top.sv
// Testbench for x86_shift_rotate_unit_top: directed and random shift/rotate requests,
// each result checked against a local predictor of the x86 shift/rotate rules.
// Depends on srot_pkg and the RTL of the block.
module tb_x86_shift_rotate_unit_top;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_REQS = 1400;

  typedef struct {
    logic [srot_pkg::VALUE_W-1:0] result;
    logic                         carry;
  } shift_res_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [srot_pkg::ACTION_W-1:0] action_i;
  logic                          wide_i;
  logic [srot_pkg::VALUE_W-1:0]  value_i;
  logic [srot_pkg::COUNT_W-1:0]  count_i;
  logic                          carry_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [srot_pkg::VALUE_W-1:0]  result_o;
  logic                          carry_out_o;

  shift_res_t expected_shifts[$];
  int         error_count = 0;
  int         idle_cycles = 0;
  bit         gaps_on = 1'b1;
  int         sink_hold = 0;
  int         sink_stall = 0;

  x86_shift_rotate_unit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .wide_i      (wide_i),
    .value_i     (value_i),
    .count_i     (count_i),
    .carry_in_i  (carry_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .carry_out_o (carry_out_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    return gaps_on ? int'($urandom_range(0, 4)) : 0;
  endfunction

  // rotate the low m bits of x by n (n < m)
  function automatic bit [63:0] rotate_bits(bit [63:0] x, int unsigned n, int unsigned m,
                                             bit left);
    bit [63:0] msk;
    msk = (64'd1 << m) - 64'd1;
    x &= msk;
    if (n == 0) return x;
    if (left) return ((x << n) | (x >> (m - n))) & msk;
    return ((x >> n) | (x << (m - n))) & msk;
  endfunction

  function automatic shift_res_t calc_shift_rotate(srot_pkg::action_e act, bit wide,
                                                   bit [31:0] value, bit [4:0] count,
                                                   bit cin);
    int unsigned w;
    bit [63:0]   msk;
    bit [63:0]   v;
    bit [63:0]   y;
    bit [63:0]   sx;
    bit          neg;
    shift_res_t  r;
    w = wide ? 32 : 8;
    msk = (64'd1 << w) - 64'd1;
    v = value & msk;
    r.result = v[31:0];
    r.carry = cin;
    case (act)
      srot_pkg::ACT_ROL: r.result = 32'(rotate_bits(v, count % w, w, 1'b1));
      srot_pkg::ACT_ROR: r.result = 32'(rotate_bits(v, count % w, w, 1'b0));
      srot_pkg::ACT_RCL, srot_pkg::ACT_RCR: begin
        // carry sits just above the operand's top bit
        y = rotate_bits(v | (64'(cin) << w), count % (w + 1), w + 1,
                        act == srot_pkg::ACT_RCL);
        r.result = 32'(y & msk);
        r.carry = y[w];
      end
      srot_pkg::ACT_SHL: begin
        y = v << count;
        r.result = 32'(y & msk);
        r.carry = count == 0 ? 1'b0 : y[w];
      end
      srot_pkg::ACT_SHR: begin
        y = ((v << 1) | 64'(cin)) >> count;
        r.result = 32'((y >> 1) & msk);
        r.carry = y[0];
      end
      srot_pkg::ACT_SAR: begin
        neg = v[w-1];
        sx = neg ? (v | ~msk) : v;
        y = ((sx << 1) | 64'(cin)) >> count;
        if (neg && count != 0) y |= ~(~64'd0 >> count);
        r.result = 32'((y >> 1) & msk);
        r.carry = y[0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit [31:0] rand_value();
    bit [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'd1 << $urandom_range(0, 31);
      3: v = ~(32'd1 << $urandom_range(0, 31));
      4: v = $urandom() | 32'h8000_0080;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_request(srot_pkg::action_e act, bit wide, bit [31:0] value,
                              bit [4:0] count, bit cin);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    wide_i     <= wide;
    value_i    <= value;
    count_i    <= count;
    carry_in_i <= cin;
    do @(posedge clk_i); while (!in_ready_o);
    expected_shifts.push_back(calc_shift_rotate(act, wide, value, count, cin));
  endtask

  task automatic send_random();
    send_request(srot_pkg::action_e'($urandom_range(0, 6)), 1'($urandom()), rand_value(),
                 5'($urandom_range(0, 31)), 1'($urandom()));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_shifts.size() != 0) @(posedge clk_i);
  endtask

  // zero count on every code, the unused one included; carry_in is 1 so shl clearing shows
  task automatic test_zero_count();
    for (int a = 0; a < 8; a++) begin
      send_request(srot_pkg::action_e'(a), a[0], 32'h8000_00A5, 5'd0, 1'b1);
    end
  endtask

  task automatic test_wide_counts();
    send_request(srot_pkg::ACT_ROL, 1'b0, 32'h0000_0096, 5'd8, 1'b0);
    send_request(srot_pkg::ACT_ROL, 1'b0, 32'h0000_0096, 5'd13, 1'b1);
    send_request(srot_pkg::ACT_ROR, 1'b0, 32'h0000_0069, 5'd31, 1'b0);
    send_request(srot_pkg::ACT_RCL, 1'b0, 32'h0000_00C3, 5'd9, 1'b1);
    send_request(srot_pkg::ACT_RCL, 1'b0, 32'h0000_00C3, 5'd17, 1'b1);
    send_request(srot_pkg::ACT_RCR, 1'b0, 32'h0000_0081, 5'd30, 1'b0);
    send_request(srot_pkg::ACT_RCL, 1'b1, 32'hC000_0001, 5'd31, 1'b1);
    send_request(srot_pkg::ACT_RCR, 1'b1, 32'h0000_0001, 5'd1, 1'b1);
    send_request(srot_pkg::ACT_SHL, 1'b0, 32'h0000_0001, 5'd8, 1'b0);
    send_request(srot_pkg::ACT_SHL, 1'b0, 32'h0000_00FF, 5'd9, 1'b1);
    send_request(srot_pkg::ACT_SHR, 1'b0, 32'h0000_0080, 5'd8, 1'b0);
    send_request(srot_pkg::ACT_SHR, 1'b0, 32'h0000_00FF, 5'd20, 1'b1);
    send_request(srot_pkg::ACT_SAR, 1'b0, 32'h0000_0080, 5'd12, 1'b0);
    send_request(srot_pkg::ACT_SAR, 1'b1, 32'h8000_0000, 5'd31, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_request(srot_pkg::ACT_SHL, 1'b1, 32'hFFFF_FFFF, 5'd31, 1'b0);
    send_request(srot_pkg::ACT_SHR, 1'b1, 32'hFFFF_FFFF, 5'd31, 1'b1);
    // upper bits must not leak into an 8-bit operation
    send_request(srot_pkg::ACT_ROL, 1'b0, 32'hFFFF_FF5A, 5'd3, 1'b0);
    send_request(srot_pkg::ACT_ROR, 1'b1, 32'h0000_0000, 5'd17, 1'b1);
  endtask

  // result side held off long enough for the pipeline to fill and block new requests
  task automatic test_output_stall();
    gaps_on = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    sink_hold = 60;
    repeat (30) send_random();
    gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (10) send_random();
    wait_drained();
    repeat (10) send_random();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 100 == 0) gaps_on = $urandom_range(0, 3) != 0;
      send_random();
    end
    gaps_on = 1'b1;
  endtask

  // result sink: per-result random stall, plus a long hold when a test asks for one
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        out_ready_i <= 1'b0;
        sink_hold--;
      end else if (sink_stall > 0) begin
        out_ready_i <= 1'b0;
        sink_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    shift_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      sink_stall = draw_gap();
      if (expected_shifts.size() == 0) begin
        $error("result with no request pending: result %h carry_out %b", result_o,
               carry_out_o);
        error_count++;
      end else begin
        exp_res = expected_shifts.pop_front();
        if (result_o !== exp_res.result) begin
          $error("result: expected %h, got %h", exp_res.result, result_o);
          error_count++;
        end
        if (carry_out_o !== exp_res.carry) begin
          $error("carry_out: expected %b, got %b", exp_res.carry, carry_out_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = srot_pkg::ACT_ROL;
    wide_i      = 1'b0;
    value_i     = '0;
    count_i     = '0;
    carry_in_i  = 1'b0;
    out_ready_i = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_count();
    test_wide_counts();
    test_field_extremes();
    test_output_stall();
    test_sender_pause();
    test_random_mix();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_shifts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
